// ===== src/lprf_pkg.sv =====
`default_nettype none
package lprf_pkg;

    localparam int MAX_TAPS_DEF    = 32;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int COEF_BITS_DEF   = 16;

    localparam int RES_W           = 32;
    localparam int SAMPLE_W        = 32;
    localparam int COEF_W          = 16;
    localparam int IDX_W           = 5;
    localparam int ORDER_W         = 6;
    localparam int SHIFT_W         = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 6;
    localparam int FIXED_ORDER_MAX = 4;

    localparam logic signed [RES_W-1:0] FIX_2 = RES_W'(2);
    localparam logic signed [RES_W-1:0] FIX_3 = RES_W'(3);
    localparam logic signed [RES_W-1:0] FIX_4 = RES_W'(4);
    localparam logic signed [RES_W-1:0] FIX_6 = RES_W'(6);

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_LOAD   = 1'b1
    } t_func;

    typedef enum logic {
        MODE_FIXED = 1'b0,
        MODE_LPC   = 1'b1
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_ORDER = 2'd1,
        CFG_SHIFT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic shift;
        logic capture;
        logic load;
        logic tap_on;
    } t_cell_ctl;

    typedef struct packed {
        logic signed [RES_W-1:0] x;
        logic                    warm;
        logic                    lpc;
        logic signed [RES_W-1:0] fixed_res;
    } t_side;

    function automatic logic signed [RES_W-1:0] fixed_residual(
        input logic [ORDER_W-1:0]    ord,
        input logic signed [RES_W-1:0] x,
        input logic signed [RES_W-1:0] h0,
        input logic signed [RES_W-1:0] h1,
        input logic signed [RES_W-1:0] h2,
        input logic signed [RES_W-1:0] h3
    );
        logic signed [RES_W-1:0] pred;
        case (ord)
            ORDER_W'(1): pred = h0;
            ORDER_W'(2): pred = FIX_2 * h0 - h1;
            ORDER_W'(3): pred = FIX_3 * h0 - FIX_3 * h1 + h2;
            ORDER_W'(4): pred = FIX_4 * h0 - FIX_6 * h1 + FIX_4 * h2 - h3;
            default:     pred = '0;
        endcase
        return x - pred;
    endfunction

endpackage
`default_nettype wire

// ===== src/lprf_in_if.sv =====
`default_nettype none
interface lprf_in_if import lprf_pkg::*;;
    logic                     valid;
    logic                     ready;
    t_func                    func;
    logic                     block_start;
    logic signed [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;

    modport source (output valid, func, block_start, sample, coef_index, coef_value,
                    input ready);
    modport sink   (input valid, func, block_start, sample, coef_index, coef_value,
                    output ready);
endinterface
`default_nettype wire

// ===== src/lprf_out_if.sv =====
`default_nettype none
interface lprf_out_if import lprf_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] residual;
    logic                    is_warmup;

    modport source (output valid, residual, is_warmup, input ready);
    modport sink   (input valid, residual, is_warmup, output ready);
endinterface
`default_nettype wire

// ===== src/lprf_cfg_if.sv =====
`default_nettype none
interface lprf_cfg_if import lprf_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/lprf_tap_cell.sv =====
`default_nettype none
module lprf_tap_cell import lprf_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  logic                                  i_clk,
    input  t_cell_ctl                             i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]         i_hist,
    input  logic signed [COEF_BITS-1:0]           i_coef,
    output logic signed [SAMPLE_BITS-1:0]         o_hist,
    output logic signed [SAMPLE_BITS+COEF_BITS-1:0] o_prod
);

    logic signed [SAMPLE_BITS-1:0]           r_hist;
    logic signed [COEF_BITS-1:0]             r_coef;
    logic signed [SAMPLE_BITS+COEF_BITS-1:0] r_prod;
    logic signed [SAMPLE_BITS+COEF_BITS-1:0] n_prod;

    always_comb begin
        if (i_ctl.tap_on) begin
            n_prod = r_coef * r_hist;
        end else begin
            n_prod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_hist <= i_hist;
        end
        if (i_ctl.load) begin
            r_coef <= i_coef;
        end
        if (i_ctl.capture) begin
            r_prod <= n_prod;
        end
    end

    assign o_hist = r_hist;
    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ===== src/lprf_sum_tree.sv =====
`default_nettype none
module lprf_sum_tree import lprf_pkg::*; #(
    parameter int LEAVES = MAX_TAPS_DEF,
    parameter int IN_W   = SAMPLE_BITS_DEF + COEF_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic [$clog2(LEAVES)-1:0]              i_en,
    input  logic signed [IN_W-1:0]                 i_leaf [LEAVES],
    output logic signed [IN_W+$clog2(LEAVES)-1:0]  o_sum
);

    localparam int LEVELS = $clog2(LEAVES);
    localparam int PAD    = 1 << LEVELS;
    localparam int SUM_W  = IN_W + LEVELS;

    logic signed [SUM_W-1:0] w_leaf [PAD];
    logic signed [SUM_W-1:0] r_node [1:PAD-1];

    for (genvar i = 0; i < PAD; i++) begin : g_leaf
        if (i < LEAVES) begin : g_used
            assign w_leaf[i] = SUM_W'(i_leaf[i]);
        end else begin : g_pad
            assign w_leaf[i] = '0;
        end
    end

    for (genvar lv = 0; lv < LEVELS; lv++) begin : g_lvl
        for (genvar j = (PAD >> (lv + 1)); j < (PAD >> lv); j++) begin : g_node
            if (lv == 0) begin : g_from_leaf
                always_ff @(posedge i_clk) begin
                    if (i_en[lv]) begin
                        r_node[j] <= w_leaf[2*j-PAD] + w_leaf[2*j+1-PAD];
                    end
                end
            end else begin : g_from_node
                always_ff @(posedge i_clk) begin
                    if (i_en[lv]) begin
                        r_node[j] <= r_node[2*j] + r_node[2*j+1];
                    end
                end
            end
        end
    end

    assign o_sum = r_node[1];

endmodule
`default_nettype wire

// ===== src/lpc_prediction_residual_filter.sv =====
`default_nettype none
// Prediction residual filter. Each audio sample beat yields one residual beat: the sample
// minus a prediction from earlier samples, or the sample itself while the block is still in
// warm-up (the first order samples after block_start). Mode 1 uses the loaded coefficients
// and an arithmetic right shift by quant_shift; mode 0 uses the fixed polynomial predictors,
// with orders above four treated as four. A coefficient load beat gives no result. The block
// accepts one beat per cycle until back-pressure from the output fills the pipeline; a result
// passes through the product stage of the tap cells, the registered adder tree and the output
// stage. Write configuration only while no results are outstanding.
module lpc_prediction_residual_filter import lprf_pkg::*; #(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = COEF_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lprf_in_if.sink    i_in,
    lprf_cfg_if.sink   i_cfg,
    lprf_out_if.source o_out
);

    localparam int CELLS  = (MAX_TAPS > FIXED_ORDER_MAX) ? MAX_TAPS : FIXED_ORDER_MAX;
    localparam int LEVELS = $clog2(CELLS);
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int SUM_W  = PROD_W + LEVELS;
    localparam int EXT_W  = (SUM_W > RES_W) ? SUM_W : RES_W;
    localparam int STAGES = LEVELS + 2;
    localparam logic [ORDER_W-1:0] CNT_MAX = '1;

    t_mode                r_mode;
    logic [ORDER_W-1:0]   r_order;
    logic [SHIFT_W-1:0]   r_shift;
    logic [ORDER_W-1:0]   r_cnt;
    logic [ORDER_W-1:0]   n_cnt;
    logic [STAGES-1:0]    r_v;
    logic [STAGES-1:0]    w_en;
    t_side                r_side [0:LEVELS];
    t_side                n_side;
    logic signed [RES_W-1:0] r_res;
    logic signed [RES_W-1:0] n_res;
    logic                 r_warm;

    logic                 w_acc;
    logic                 w_acc_smp;
    logic                 w_acc_load;
    logic [ORDER_W-1:0]   w_order_eff;
    logic [ORDER_W-1:0]   w_cnt_base;
    logic signed [SAMPLE_BITS-1:0] w_xs;
    logic signed [COEF_BITS-1:0]   w_cv;
    logic signed [RES_W-1:0]       w_x;

    t_cell_ctl                  w_ctl  [CELLS];
    logic signed [SAMPLE_BITS-1:0] w_hist [CELLS];
    logic signed [PROD_W-1:0]   w_prod [CELLS];
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [EXT_W-1:0]    w_sum_ext;
    logic signed [EXT_W-1:0]    w_pred_ext;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_FIXED;
            r_order <= '0;
            r_shift <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MODE:  r_mode  <= t_mode'(i_cfg.data[0]);
                CFG_ORDER: r_order <= i_cfg.data[ORDER_W-1:0];
                CFG_SHIFT: r_shift <= i_cfg.data[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // stall back from the output register, squeezing out empty stages
    always_comb begin
        w_en[STAGES-1] = !r_v[STAGES-1] || o_out.ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            w_en[i] = !r_v[i] || w_en[i+1];
        end
    end

    assign i_in.ready = w_en[0];
    assign w_acc      = i_in.valid && w_en[0];
    assign w_acc_smp  = w_acc && (i_in.func == FUNC_SAMPLE);
    assign w_acc_load = w_acc && (i_in.func == FUNC_LOAD);

    assign w_xs = i_in.sample[SAMPLE_BITS-1:0];
    assign w_cv = i_in.coef_value[COEF_BITS-1:0];
    assign w_x  = RES_W'(w_xs);

    always_comb begin
        if (r_mode == MODE_LPC) begin
            w_order_eff = (r_order > ORDER_W'(MAX_TAPS)) ? ORDER_W'(MAX_TAPS) : r_order;
        end else begin
            w_order_eff = (r_order > ORDER_W'(FIXED_ORDER_MAX)) ?
                          ORDER_W'(FIXED_ORDER_MAX) : r_order;
        end
        w_cnt_base = i_in.block_start ? '0 : r_cnt;
        n_cnt      = (w_cnt_base == CNT_MAX) ? CNT_MAX : w_cnt_base + ORDER_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_acc_smp) begin
            r_cnt <= n_cnt;
        end
    end

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        assign w_ctl[k].shift   = w_acc_smp;
        assign w_ctl[k].capture = w_en[0];
        assign w_ctl[k].load    = w_acc_load && (i_in.coef_index == IDX_W'(k)) &&
                                  (k < MAX_TAPS);
        assign w_ctl[k].tap_on  = ORDER_W'(k) < w_order_eff;

        if (k == 0) begin : g_head
            lprf_tap_cell #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .COEF_BITS  (COEF_BITS)
            ) u_cell (
                .i_clk (i_clk),
                .i_ctl (w_ctl[k]),
                .i_hist(w_xs),
                .i_coef(w_cv),
                .o_hist(w_hist[k]),
                .o_prod(w_prod[k])
            );
        end else begin : g_body
            lprf_tap_cell #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .COEF_BITS  (COEF_BITS)
            ) u_cell (
                .i_clk (i_clk),
                .i_ctl (w_ctl[k]),
                .i_hist(w_hist[k-1]),
                .i_coef(w_cv),
                .o_hist(w_hist[k]),
                .o_prod(w_prod[k])
            );
        end
    end

    lprf_sum_tree #(
        .LEAVES(CELLS),
        .IN_W  (PROD_W)
    ) u_tree (
        .i_clk (i_clk),
        .i_en  (w_en[LEVELS:1]),
        .i_leaf(w_prod),
        .o_sum (w_sum)
    );

    always_comb begin
        n_side.x         = w_x;
        n_side.warm      = w_cnt_base < w_order_eff;
        n_side.lpc       = (r_mode == MODE_LPC);
        n_side.fixed_res = fixed_residual(w_order_eff, w_x,
                                          RES_W'(w_hist[0]), RES_W'(w_hist[1]),
                                          RES_W'(w_hist[2]), RES_W'(w_hist[3]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= w_acc_smp;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= n_side;
        end
        for (int i = 1; i <= LEVELS; i++) begin
            if (w_en[i]) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    always_comb begin
        w_sum_ext  = EXT_W'(w_sum);
        w_pred_ext = w_sum_ext >>> r_shift;
        if (r_side[LEVELS].warm) begin
            n_res = r_side[LEVELS].x;
        end else if (r_side[LEVELS].lpc) begin
            n_res = r_side[LEVELS].x - w_pred_ext[RES_W-1:0];
        end else begin
            n_res = r_side[LEVELS].fixed_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[STAGES-1]) begin
            r_res  <= n_res;
            r_warm <= r_side[LEVELS].warm;
        end
    end

    assign o_out.valid     = r_v[STAGES-1];
    assign o_out.residual  = r_res;
    assign o_out.is_warmup = r_warm;

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_load |=> !r_v[0])
        else $error("load beat entered the residual pipeline");

    a_block_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_smp && i_in.block_start && (w_order_eff != '0)) |=> r_side[0].warm)
        else $error("first sample of block not flagged as warm-up");

    a_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (&r_v))
        else $error("input stalled with an empty pipeline stage");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[STAGES-1] && !o_out.ready) |=> (r_v[STAGES-1] && $stable(r_res)
                                             && $stable(r_warm)))
        else $error("stalled result changed");

    a_cnt_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_smp && i_in.block_start) |=> (r_cnt == ORDER_W'(1)))
        else $error("block counter not restarted");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import lprf_pkg::*;

    localparam int unsigned ITEM_GOAL      = 1650;
    localparam int unsigned SETTLE_CYCLES  = 12;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HIST_DEPTH     = 32;
    localparam int unsigned BLOCK_CNT_MAX  = 63;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
    localparam logic signed [COEF_W-1:0]   COEF_MAX   = 16'sh7fff;
    localparam logic signed [COEF_W-1:0]   COEF_MIN   = 16'sh8000;

    typedef struct {
        t_func                      func;
        logic                       block_start;
        logic signed [SAMPLE_W-1:0] sample;
        logic [IDX_W-1:0]           coef_index;
        logic signed [COEF_W-1:0]   coef_value;
    } t_in_beat;

    typedef struct {
        logic signed [RES_W-1:0] residual;
        logic                    is_warmup;
    } t_residual;

    class residual_tracker;
        t_mode                      mode;
        logic [ORDER_W-1:0]         order;
        logic [SHIFT_W-1:0]         shift;
        logic signed [SAMPLE_W-1:0] history [HIST_DEPTH];
        logic signed [COEF_W-1:0]   coefs [HIST_DEPTH];
        int unsigned                blk_count;
        t_residual                  residual_q [$];
        int unsigned                errors;

        function new();
            mode      = MODE_FIXED;
            order     = '0;
            shift     = '0;
            blk_count = 0;
            errors    = 0;
            foreach (history[k]) begin
                history[k] = '0;
                coefs[k]   = '0;
            end
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MODE:  mode = t_mode'(data[0]);
                CFG_ORDER: order = data[ORDER_W-1:0];
                CFG_SHIFT: shift = data[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_beat(t_in_beat b);
            int unsigned eff;
            longint      pred;
            longint      h0, h1, h2, h3;
            logic        warm;
            longint      diff;
            t_residual   r;
            if (b.func == FUNC_LOAD) begin
                if (b.coef_index < MAX_TAPS_DEF)
                    coefs[b.coef_index] = b.coef_value;
                return;
            end
            if (b.block_start)
                blk_count = 0;
            eff = order;
            if (mode == MODE_LPC) begin
                if (eff > MAX_TAPS_DEF)
                    eff = MAX_TAPS_DEF;
            end else if (eff > FIXED_ORDER_MAX) begin
                eff = FIXED_ORDER_MAX;
            end
            warm = blk_count < eff;
            if (warm) begin
                diff = longint'(b.sample);
            end else begin
                pred = 0;
                h0 = longint'(history[0]);
                h1 = longint'(history[1]);
                h2 = longint'(history[2]);
                h3 = longint'(history[3]);
                if (mode == MODE_LPC) begin
                    for (int k = 0; k < eff; k++)
                        pred += longint'(coefs[k]) * longint'(history[k]);
                    pred = pred >>> shift;
                end else begin
                    case (eff)
                        1: pred = h0;
                        2: pred = 2 * h0 - h1;
                        3: pred = 3 * h0 - 3 * h1 + h2;
                        4: pred = 4 * h0 - 6 * h1 + 4 * h2 - h3;
                        default: pred = 0;
                    endcase
                end
                diff = longint'(b.sample) - pred;
            end
            r.residual  = diff[RES_W-1:0];
            r.is_warmup = warm;
            residual_q.push_back(r);
            for (int k = HIST_DEPTH - 1; k > 0; k--)
                history[k] = history[k-1];
            history[0] = b.sample;
            if (blk_count < BLOCK_CNT_MAX)
                blk_count++;
        endfunction

        function void check_residual(logic signed [RES_W-1:0] res, logic warm);
            t_residual want;
            if (residual_q.size() == 0) begin
                $error("residual beat with no sample waiting: residual %0d", res);
                errors++;
                return;
            end
            want = residual_q.pop_front();
            if (res !== want.residual) begin
                $error("residual: expected %0d, actual %0d", want.residual, res);
                errors++;
            end
            if (warm !== want.is_warmup) begin
                $error("is_warmup: expected %0b, actual %0b", want.is_warmup, warm);
                errors++;
            end
        endfunction

        function int pending();
            return residual_q.size();
        endfunction

        function void report_leftover();
            if (residual_q.size() != 0) begin
                $error("%0d residual beats never arrived", residual_q.size());
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lprf_in_if  in_bus ();
    lprf_cfg_if cfg_bus ();
    lprf_out_if out_bus ();

    lpc_prediction_residual_filter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .i_cfg   (cfg_bus),
        .o_out   (out_bus)
    );

    residual_tracker tracker = new();

    logic signed [SAMPLE_W-1:0] last_sample = '0;
    int unsigned                blk_left    = 0;
    int unsigned                item_total  = 0;
    bit                         in_calm     = 1'b0;
    bit                         out_calm    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        logic signed [SAMPLE_W-1:0] x;
        case ($urandom_range(0, 9))
            0, 1, 2:    x = $urandom;
            3, 4, 5, 6: x = last_sample + (int'($urandom_range(0, 4000)) - 2000);
            7, 8:       x = int'($urandom_range(0, 2000)) - 1000;
            default: begin
                case ($urandom_range(0, 4))
                    0:       x = SAMPLE_MAX;
                    1:       x = SAMPLE_MIN;
                    2:       x = '0;
                    3:       x = -1;
                    default: x = 1;
                endcase
            end
        endcase
        last_sample = x;
        return x;
    endfunction

    function automatic logic signed [COEF_W-1:0] draw_coef();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return '0;
                    default: return -1;
                endcase
            end
            1, 2, 3, 4, 5: return COEF_W'(int'($urandom_range(0, 4095)) - 2048);
            default:       return COEF_W'($urandom);
        endcase
    endfunction

    function automatic t_in_beat sample_beat(logic bs, logic signed [SAMPLE_W-1:0] x);
        t_in_beat b;
        b.func        = FUNC_SAMPLE;
        b.block_start = bs;
        b.sample      = x;
        b.coef_index  = IDX_W'($urandom);
        b.coef_value  = COEF_W'($urandom);
        return b;
    endfunction

    function automatic t_in_beat load_beat(logic bs, int unsigned idx,
                                           logic signed [COEF_W-1:0] val);
        t_in_beat b;
        b.func        = FUNC_LOAD;
        b.block_start = bs;
        b.sample      = $urandom;
        b.coef_index  = IDX_W'(idx);
        b.coef_value  = val;
        return b;
    endfunction

    function automatic t_in_beat next_beat();
        logic bs;
        if ($urandom_range(0, 99) < 12)
            return load_beat(1'($urandom_range(0, 1)), $urandom_range(0, 31), draw_coef());
        bs = (blk_left == 0) || ($urandom_range(0, 99) < 2);
        if (bs)
            blk_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 40)
                                                  : $urandom_range(64, 140);
        blk_left--;
        return sample_beat(bs, draw_sample());
    endfunction

    task automatic send_beat(input t_in_beat b);
        int unsigned gap;
        in_bus.valid       <= 1'b1;
        in_bus.func        <= b.func;
        in_bus.block_start <= b.block_start;
        in_bus.sample      <= b.sample;
        in_bus.coef_index  <= b.coef_index;
        in_bus.coef_value  <= b.coef_value;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        tracker.note_beat(b);
        item_total++;
        gap = in_calm ? 0 : draw_gap();
        if (gap != 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        tracker.write_reg(idx, CFG_DATA_W'(value));
    endtask

    task automatic configure(input t_mode mode, input int unsigned order,
                             input int unsigned shift);
        in_bus.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(CFG_MODE, mode);
        write_reg(CFG_ORDER, order);
        write_reg(CFG_SHIFT, shift);
        cfg_bus.valid <= 1'b0;
    endtask

    initial begin
        int unsigned stall;
        stall = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
                tracker.check_residual(out_bus.residual, out_bus.is_warmup);
            if (stall != 0) begin
                out_bus.ready <= 1'b0;
                stall--;
            end else begin
                out_bus.ready <= 1'b1;
                if (!out_calm)
                    stall = draw_gap();
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
                (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1) ||
                (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        t_mode       mode;
        int unsigned order;
        int unsigned shift;
        int unsigned n;
        int unsigned phase;
        int unsigned r;

        i_rst_n            <= 1'b0;
        in_bus.valid       <= 1'b0;
        in_bus.func        <= FUNC_SAMPLE;
        in_bus.block_start <= 1'b0;
        in_bus.sample      <= '0;
        in_bus.coef_index  <= '0;
        in_bus.coef_value  <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= CFG_MODE;
        cfg_bus.data       <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pass-through at reset settings, load ignores block start
        send_beat(sample_beat(1'b1, SAMPLE_MAX));
        send_beat(sample_beat(1'b0, SAMPLE_MIN));
        send_beat(sample_beat(1'b0, '0));
        send_beat(sample_beat(1'b0, -1));
        send_beat(load_beat(1'b1, 31, COEF_MIN));
        send_beat(load_beat(1'b0, 0, COEF_MAX));

        configure(MODE_FIXED, FIXED_ORDER_MAX, 0);
        for (int k = 0; k < 3; k++) begin
            send_beat(sample_beat(k == 0, SAMPLE_MAX));
            send_beat(sample_beat(1'b0, SAMPLE_MIN));
        end

        configure(MODE_LPC, 2, 31);
        send_beat(load_beat(1'b1, 1, COEF_MIN));
        send_beat(sample_beat(1'b1, SAMPLE_MIN));
        send_beat(sample_beat(1'b0, SAMPLE_MAX));
        send_beat(sample_beat(1'b0, SAMPLE_MIN));

        // raise order mid-block: re-enter warm-up, clamp fixed order
        configure(MODE_FIXED, 7, 0);
        send_beat(sample_beat(1'b0, 12345));
        send_beat(sample_beat(1'b0, -7));

        for (int k = 0; k < HIST_DEPTH; k++)
            send_beat(load_beat(1'($urandom_range(0, 1)), k, draw_coef()));

        phase = 0;
        while (item_total < ITEM_GOAL) begin
            r = $urandom_range(0, 9);
            mode = t_mode'($urandom_range(0, 1));
            if (mode == MODE_FIXED)
                order = (r < 7) ? $urandom_range(0, 4)
                      : (r < 9) ? $urandom_range(5, 32) : $urandom_range(33, 63);
            else
                order = (r < 6) ? $urandom_range(0, 12)
                      : (r < 8) ? $urandom_range(13, 32)
                      : (r < 9) ? MAX_TAPS_DEF : $urandom_range(33, 63);
            r = $urandom_range(0, 9);
            shift = (r == 0) ? 0 : (r == 1) ? 31
                  : (r < 6) ? $urandom_range(9, 15) : $urandom_range(0, 31);
            case (phase)
                0: begin mode = MODE_LPC;   order = MAX_TAPS_DEF; shift = 0;  end
                1: begin mode = MODE_LPC;   order = 63;           shift = 31; end
                2: begin mode = MODE_FIXED; order = 63;                       end
                default: ;
            endcase
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            configure(mode, order, shift);
            if ($urandom_range(0, 1) == 1)
                blk_left = 0;
            n = $urandom_range(20, 110);
            for (int i = 0; i < n; i++)
                send_beat(next_beat());
            phase++;
        end

        in_bus.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        tracker.report_leftover();
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
